[design/kbsq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package kbsq_pkg;

    localparam int FIFO_DEPTH_DEF = 256;
    localparam int KEY_SLOTS      = 128;
    localparam int KEY_W          = 7;
    localparam int SCAN_W         = 8;
    localparam int CNT_OUT_W      = 8;

    localparam logic [KEY_W-1:0] SC_LSHIFT = 7'h2A;
    localparam logic [KEY_W-1:0] SC_RSHIFT = 7'h36;
    localparam logic [KEY_W-1:0] SC_LCTRL  = 7'h1D;
    localparam logic [KEY_W-1:0] SC_KEY_A  = 7'h1E;
    localparam logic [KEY_W-1:0] CTRL_A    = 7'h01;

    localparam logic REQ_SCAN = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic exec;    // run the accepted item
        logic finish;  // load result registers
    } t_cmd;

    function automatic logic [KEY_W-1:0] normal_char(input logic [KEY_W-1:0] key);
        logic [KEY_W-1:0] c;
        unique case (key)
            7'h02: c = 7'h31;  7'h03: c = 7'h32;  7'h04: c = 7'h33;  7'h05: c = 7'h34;
            7'h06: c = 7'h35;  7'h07: c = 7'h36;  7'h08: c = 7'h37;  7'h09: c = 7'h38;
            7'h0A: c = 7'h39;  7'h0B: c = 7'h30;  7'h0C: c = 7'h2D;  7'h0D: c = 7'h3D;
            7'h0E: c = 7'h08;
            7'h10: c = 7'h71;  7'h11: c = 7'h77;  7'h12: c = 7'h65;  7'h13: c = 7'h72;
            7'h14: c = 7'h74;  7'h15: c = 7'h79;  7'h16: c = 7'h75;  7'h17: c = 7'h69;
            7'h18: c = 7'h6F;  7'h19: c = 7'h70;  7'h1A: c = 7'h5B;  7'h1B: c = 7'h5D;
            7'h1C: c = 7'h0A;
            7'h1E: c = 7'h61;  7'h1F: c = 7'h73;  7'h20: c = 7'h64;  7'h21: c = 7'h66;
            7'h22: c = 7'h67;  7'h23: c = 7'h68;  7'h24: c = 7'h6A;  7'h25: c = 7'h6B;
            7'h26: c = 7'h6C;  7'h27: c = 7'h3B;  7'h28: c = 7'h27;  7'h2B: c = 7'h5C;
            7'h2C: c = 7'h7A;  7'h2D: c = 7'h78;  7'h2E: c = 7'h63;  7'h2F: c = 7'h76;
            7'h30: c = 7'h62;  7'h31: c = 7'h6E;  7'h32: c = 7'h6D;  7'h33: c = 7'h2C;
            7'h34: c = 7'h2E;  7'h35: c = 7'h2F;
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic [KEY_W-1:0] shift_char(input logic [KEY_W-1:0] key);
        logic [KEY_W-1:0] c;
        unique case (key)
            7'h02: c = 7'h21;  7'h03: c = 7'h40;  7'h04: c = 7'h23;  7'h05: c = 7'h24;
            7'h06: c = 7'h25;  7'h07: c = 7'h5E;  7'h08: c = 7'h26;  7'h09: c = 7'h2A;
            7'h0A: c = 7'h28;  7'h0B: c = 7'h29;  7'h0C: c = 7'h5F;  7'h0D: c = 7'h2B;
            7'h0E: c = 7'h08;
            7'h10: c = 7'h51;  7'h11: c = 7'h57;  7'h12: c = 7'h45;  7'h13: c = 7'h52;
            7'h14: c = 7'h54;  7'h15: c = 7'h59;  7'h16: c = 7'h55;  7'h17: c = 7'h49;
            7'h18: c = 7'h4F;  7'h19: c = 7'h50;  7'h1A: c = 7'h7B;  7'h1B: c = 7'h7D;
            7'h1C: c = 7'h0A;
            7'h1E: c = 7'h41;  7'h1F: c = 7'h53;  7'h20: c = 7'h44;  7'h21: c = 7'h46;
            7'h22: c = 7'h47;  7'h23: c = 7'h48;  7'h24: c = 7'h4A;  7'h25: c = 7'h4B;
            7'h26: c = 7'h4C;  7'h27: c = 7'h3A;  7'h28: c = 7'h22;  7'h2B: c = 7'h7C;
            7'h2C: c = 7'h5A;  7'h2D: c = 7'h58;  7'h2E: c = 7'h43;  7'h2F: c = 7'h56;
            7'h30: c = 7'h42;  7'h31: c = 7'h4E;  7'h32: c = 7'h4D;  7'h33: c = 7'h3C;
            7'h34: c = 7'h3E;  7'h35: c = 7'h3F;
            default: c = '0;
        endcase
        return c;
    endfunction

    // ctrl wins over shift; only 'a' has a ctrl character
    function automatic logic [KEY_W-1:0] key_to_ascii(input logic [KEY_W-1:0] key,
                                                      input logic shift,
                                                      input logic ctrl);
        logic [KEY_W-1:0] c;
        if (ctrl) begin
            c = (key == SC_KEY_A) ? CTRL_A : '0;
        end else if (shift) begin
            c = shift_char(key);
        end else begin
            c = normal_char(key);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[design/kbsq_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module kbsq_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output kbsq_pkg::t_cmd     o_cmd,
    output logic               busy,
    output logic               o_strobe
);
    import kbsq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOOK = 3'b010,
        S_SHOW = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    logic w_accept;

    // FIFO read data is registered, so the lookup waits in S_LOOK
    assign busy      = (r_state == S_LOOK);
    assign w_accept  = start && !busy;
    assign o_strobe  = (r_state == S_SHOW);

    assign o_cmd.exec   = w_accept;
    assign o_cmd.finish = (r_state == S_LOOK);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  n_state = w_accept ? S_LOOK : S_IDLE;
            S_LOOK:  n_state = S_SHOW;
            S_SHOW:  n_state = w_accept ? S_LOOK : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_show_after_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == S_LOOK))
        else $error("result strobe without lookup");

    a_accept_to_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && w_accept) |=> (r_state == S_LOOK))
        else $error("accepted item did not start lookup");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("strobe longer than one cycle");

endmodule

`default_nettype wire

[design/kbsq_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none

module kbsq_dpath #(
    parameter int FIFO_DEPTH = kbsq_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire kbsq_pkg::t_cmd                    i_cmd,
    input  wire logic                              i_req_type,
    input  wire logic [kbsq_pkg::SCAN_W-1:0]       i_scan_byte,
    output logic                                   o_pop_valid,
    output logic [kbsq_pkg::KEY_W-1:0]             o_key_code,
    output logic [kbsq_pkg::KEY_W-1:0]             o_char_code,
    output logic                                   o_shift_down,
    output logic                                   o_ctrl_down,
    output logic                                   o_push_dropped,
    output logic [kbsq_pkg::CNT_OUT_W-1:0]         o_queued_count
);
    import kbsq_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam logic [AW-1:0] LAST_PTR = AW'(FIFO_DEPTH - 1);
    localparam int XW = AW + CNT_OUT_W;

    logic [KEY_W-1:0] r_mem [FIFO_DEPTH];
    logic [KEY_SLOTS-1:0] r_map;
    logic [AW-1:0] r_wptr;
    logic [AW-1:0] r_rptr;
    logic [AW-1:0] r_count;
    logic [KEY_W-1:0] r_rd_data;
    logic r_pop_hit;
    logic r_drop;

    logic [KEY_W-1:0] w_key;
    logic w_full;
    logic w_empty;
    logic w_push_ok;
    logic w_pop_ok;
    logic w_shift;
    logic w_ctrl;
    logic [XW-1:0] w_cnt_ext;

    assign w_key     = i_scan_byte[KEY_W-1:0];
    assign w_full    = (r_count == LAST_PTR);
    assign w_empty   = (r_count == '0);
    assign w_push_ok = i_cmd.exec && (i_req_type == REQ_SCAN) && !w_full;
    assign w_pop_ok  = i_cmd.exec && (i_req_type == REQ_POP) && !w_empty;
    assign w_shift   = r_map[SC_LSHIFT] || r_map[SC_RSHIFT];
    assign w_ctrl    = r_map[SC_LCTRL];
    assign w_cnt_ext = {{CNT_OUT_W{1'b0}}, r_count};

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_mem[r_wptr] <= w_key;
        end
        if (w_pop_ok) begin
            r_rd_data <= r_mem[r_rptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map     <= '0;
            r_wptr    <= '0;
            r_rptr    <= '0;
            r_count   <= '0;
            r_pop_hit <= 1'b0;
            r_drop    <= 1'b0;
        end else if (i_cmd.exec) begin
            r_pop_hit <= w_pop_ok;
            r_drop    <= (i_req_type == REQ_SCAN) && w_full;
            if (i_req_type == REQ_SCAN) begin
                // bitmap tracks the key even when the queue is full
                r_map[w_key] <= ~i_scan_byte[SCAN_W-1];
            end
            if (w_push_ok) begin
                r_wptr  <= (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
                r_count <= r_count + 1'b1;
            end
            if (w_pop_ok) begin
                r_rptr  <= (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_pop_valid    <= r_pop_hit;
            o_key_code     <= r_pop_hit ? r_rd_data : '0;
            o_char_code    <= r_pop_hit ? key_to_ascii(r_rd_data, w_shift, w_ctrl) : '0;
            o_shift_down   <= w_shift;
            o_ctrl_down    <= w_ctrl;
            o_push_dropped <= r_drop;
            o_queued_count <= (w_cnt_ext > XW'(255)) ? {CNT_OUT_W{1'b1}}
                                                     : w_cnt_ext[CNT_OUT_W-1:0];
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LAST_PTR)
        else $error("queue count above capacity");

    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && w_push_ok) |=> (r_count == $past(r_count) + 1'b1))
        else $error("push did not raise count");

    a_drop_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_cmd.exec && !w_full) |=> !r_drop)
        else $error("item dropped while queue had room");

endmodule

`default_nettype wire

[design/keyboard_scancode_queue_translator.sv]
// An item accepted at a clock edge passes through the S_LOOK and S_SHOW states; its
// result is on the outputs in S_SHOW, with o_strobe high for one cycle, and cannot
// be stalled. No new item is accepted while busy, which is high while the registered
// queue memory read feeds the ASCII lookup, but one is accepted while a result shows.
// Reset (i_rst_n low at a clock edge) clears the key bitmap, queue pointers and count;
// queue memory contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module keyboard_scancode_queue_translator #(
    parameter int FIFO_DEPTH = kbsq_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              i_req_type,
    input  wire logic [kbsq_pkg::SCAN_W-1:0]       i_scan_byte,
    output logic                                   o_strobe,
    output logic                                   o_pop_valid,
    output logic [kbsq_pkg::KEY_W-1:0]             o_key_code,
    output logic [kbsq_pkg::KEY_W-1:0]             o_char_code,
    output logic                                   o_shift_down,
    output logic                                   o_ctrl_down,
    output logic                                   o_push_dropped,
    output logic [kbsq_pkg::CNT_OUT_W-1:0]         o_queued_count
);
    import kbsq_pkg::*;

    t_cmd w_cmd;

    kbsq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .o_cmd    (w_cmd),
        .busy     (busy),
        .o_strobe (o_strobe)
    );

    kbsq_dpath #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_req_type     (i_req_type),
        .i_scan_byte    (i_scan_byte),
        .o_pop_valid    (o_pop_valid),
        .o_key_code     (o_key_code),
        .o_char_code    (o_char_code),
        .o_shift_down   (o_shift_down),
        .o_ctrl_down    (o_ctrl_down),
        .o_push_dropped (o_push_dropped),
        .o_queued_count (o_queued_count)
    );

endmodule

`default_nettype wire
